// File: src/tile_to_triangle_vertex_expander_macros.svh
// Assertion macros used by the checker file
`ifndef TILE_TO_TRIANGLE_VERTEX_EXPANDER_MACROS_SVH
`define TILE_TO_TRIANGLE_VERTEX_EXPANDER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TTVE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define TTVE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ttve_pkg.sv
`default_nettype none

package ttve_pkg;

    // Size limits
    localparam int MAX_MAP_SIDE  = 1024;
    localparam int MAX_TILE_SIZE = 256;

    // Field and datapath widths
    localparam int POS_W      = $clog2(MAX_MAP_SIDE);
    localparam int SIDE_W     = 11;
    localparam int TS_W       = 9;
    localparam int TILE_W     = 16;
    localparam int QUO_W      = TILE_W - 1;
    localparam int CELL_W     = 20;
    localparam int CORNER_W   = 3;
    localparam int XY_W       = 19;
    localparam int V_W        = 24;
    localparam int MAC_W      = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CNT_W      = 4;

    // Sequencer lengths
    localparam int VERTS     = 6;
    localparam int DIV_STEPS = QUO_W;
    localparam int MAC_STEPS = 9;

    // Quotient bit position in a divide-step result
    localparam int DIV_Q_BIT = SIDE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAC,
        ST_EMIT
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH     = 2'd0,
        CFG_MAP_HEIGHT    = 2'd1,
        CFG_TILE_SIZE     = 2'd2,
        CFG_TILES_PER_ROW = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ALU_MAC,
        ALU_DIV
    } t_alu_op;

    // Multiply-add steps, one product per step
    typedef enum logic [CNT_W-1:0] {
        MAC_CELL = 4'd0,
        MAC_XL   = 4'd1,
        MAC_XR   = 4'd2,
        MAC_YT   = 4'd3,
        MAC_YB   = 4'd4,
        MAC_UL   = 4'd5,
        MAC_UR   = 4'd6,
        MAC_VT   = 4'd7,
        MAC_VB   = 4'd8
    } t_mac_step;

    typedef struct packed {
        t_alu_op             op;
        logic [TILE_W-1:0]   a;
        logic [SIDE_W-1:0]   b;
        logic [SIDE_W-1:0]   c;
    } t_alu_req;

    // Clamped geometry seen by the sequencer
    typedef struct packed {
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
        logic [TS_W-1:0]   ts;
        logic [SIDE_W-1:0] tpr;
    } t_geom;

endpackage

`default_nettype wire

// File: src/ttve_alu.sv
`default_nettype none

module ttve_alu (
    input  ttve_pkg::t_alu_req          i_req,
    output logic [ttve_pkg::MAC_W-1:0]  o_res
);
    import ttve_pkg::*;

    logic [SIDE_W-1:0] trial;
    logic [SIDE_W-1:0] diff;
    logic              ge;

    // Restoring divide step: compare and subtract
    assign trial = i_req.a[SIDE_W-1:0];
    assign ge    = (trial >= i_req.b);
    assign diff  = trial - i_req.b;

    always_comb begin
        unique case (i_req.op)
            ALU_MAC: o_res = MAC_W'(i_req.a) * MAC_W'(i_req.b) + MAC_W'(i_req.c);
            ALU_DIV: o_res = MAC_W'({ge, (ge ? diff : trial)});
            default: o_res = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: src/ttve_ctrl.sv
`default_nettype none

module ttve_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ttve_pkg::t_geom                     i_geom,
    input  logic                                i_pos_clear,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ttve_pkg::TILE_W-1:0]  i_tile_number,
    output ttve_pkg::t_alu_req                  o_alu_req,
    input  logic [ttve_pkg::MAC_W-1:0]          i_alu_res,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ttve_pkg::CELL_W-1:0]         o_cell_index,
    output logic [ttve_pkg::CORNER_W-1:0]       o_corner,
    output logic [ttve_pkg::XY_W-1:0]           o_pos_x,
    output logic [ttve_pkg::XY_W-1:0]           o_pos_y,
    output logic [ttve_pkg::XY_W-1:0]           o_tex_u,
    output logic [ttve_pkg::V_W-1:0]            o_tex_v,
    output logic                                o_last_vertex
);
    import ttve_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [POS_W-1:0]  r_col, r_row;
    logic [POS_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [CELL_W-1:0] r_cell;
    logic [XY_W-1:0]   r_xl, r_xr, r_yt, r_yb, r_ul, r_ur;
    logic [V_W-1:0]    r_vt, r_vb;
    logic              r_out_valid;

    logic              accept, empty_cell, stale;
    logic              last_div, last_mac, last_emit, emit_load;
    logic              right, bottom;
    logic [POS_W-1:0]  eff_col, eff_row, base_col, base_row;
    logic [POS_W-1:0]  adv_col, adv_row;
    logic [SIDE_W-1:0] inc_col, inc_row;
    logic [SIDE_W-1:0] ts_ext;

    assign o_ready    = (r_state == ST_IDLE);
    assign accept     = i_valid && o_ready;
    assign empty_cell = i_tile_number[TILE_W-1];
    assign last_div   = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign last_mac   = (r_cnt == CNT_W'(MAC_STEPS - 1));
    assign last_emit  = (r_cnt == CNT_W'(VERTS - 1));
    assign emit_load  = (r_state == ST_EMIT) && (!r_out_valid || i_ready);
    assign ts_ext     = SIDE_W'(i_geom.ts);

    // Position out of range of the current map restarts at the origin
    assign stale   = ({1'b0, r_col} >= i_geom.w) || ({1'b0, r_row} >= i_geom.h);
    assign eff_col = stale ? '0 : r_col;
    assign eff_row = stale ? '0 : r_row;

    // Step to the next cell, row-major with wrap at the map end
    assign base_col = (r_state == ST_IDLE) ? eff_col : r_col;
    assign base_row = (r_state == ST_IDLE) ? eff_row : r_row;
    assign inc_col  = SIDE_W'(base_col) + SIDE_W'(1);
    assign inc_row  = SIDE_W'(base_row) + SIDE_W'(1);

    always_comb begin
        if (inc_col >= i_geom.w) begin
            adv_col = '0;
            adv_row = (inc_row >= i_geom.h) ? '0 : inc_row[POS_W-1:0];
        end else begin
            adv_col = inc_col[POS_W-1:0];
            adv_row = base_row;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept && !empty_cell) n_state = ST_DIV;
            ST_DIV:  if (last_div) n_state = ST_MAC;
            ST_MAC:  if (last_mac) n_state = ST_EMIT;
            ST_EMIT: if (emit_load && last_emit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Step counter, shared by divide, multiply and emit phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state != n_state) begin
            r_cnt <= '0;
        end else if ((r_state == ST_DIV) || (r_state == ST_MAC) || emit_load) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Cell position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_pos_clear) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= empty_cell ? adv_col : eff_col;
            r_row <= empty_cell ? adv_row : eff_row;
        end else if (emit_load && last_emit) begin
            r_col <= adv_col;
            r_row <= adv_row;
        end
    end

    // Shared unit operand selection
    always_comb begin
        o_alu_req.op = ALU_MAC;
        o_alu_req.a  = '0;
        o_alu_req.b  = '0;
        o_alu_req.c  = '0;
        if (r_state == ST_DIV) begin
            o_alu_req.op = ALU_DIV;
            o_alu_req.a  = TILE_W'({r_rem, r_quo[QUO_W-1]});
            o_alu_req.b  = i_geom.tpr;
        end else begin
            case (t_mac_step'(r_cnt))
                MAC_CELL: begin
                    o_alu_req.a = TILE_W'(r_row);
                    o_alu_req.b = i_geom.w;
                    o_alu_req.c = SIDE_W'(r_col);
                end
                MAC_XL, MAC_XR: begin
                    o_alu_req.a = TILE_W'(r_col);
                    o_alu_req.b = ts_ext;
                    o_alu_req.c = (t_mac_step'(r_cnt) == MAC_XR) ? ts_ext : '0;
                end
                MAC_YT, MAC_YB: begin
                    o_alu_req.a = TILE_W'(r_row);
                    o_alu_req.b = ts_ext;
                    o_alu_req.c = (t_mac_step'(r_cnt) == MAC_YB) ? ts_ext : '0;
                end
                MAC_UL, MAC_UR: begin
                    o_alu_req.a = TILE_W'(r_rem);
                    o_alu_req.b = ts_ext;
                    o_alu_req.c = (t_mac_step'(r_cnt) == MAC_UR) ? ts_ext : '0;
                end
                MAC_VT, MAC_VB: begin
                    o_alu_req.a = TILE_W'(r_quo);
                    o_alu_req.b = ts_ext;
                    o_alu_req.c = (t_mac_step'(r_cnt) == MAC_VB) ? ts_ext : '0;
                end
                default: o_alu_req.a = '0;
            endcase
        end
    end

    // Divider: dividend shifts out at the top, quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_quo <= i_tile_number[QUO_W-1:0];
            r_rem <= '0;
        end else if (r_state == ST_DIV) begin
            r_quo <= {r_quo[QUO_W-2:0], i_alu_res[DIV_Q_BIT]};
            r_rem <= i_alu_res[POS_W-1:0];
        end
    end

    // Products land in their own registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MAC) begin
            case (t_mac_step'(r_cnt))
                MAC_CELL: r_cell <= i_alu_res[CELL_W-1:0];
                MAC_XL:   r_xl   <= i_alu_res[XY_W-1:0];
                MAC_XR:   r_xr   <= i_alu_res[XY_W-1:0];
                MAC_YT:   r_yt   <= i_alu_res[XY_W-1:0];
                MAC_YB:   r_yb   <= i_alu_res[XY_W-1:0];
                MAC_UL:   r_ul   <= i_alu_res[XY_W-1:0];
                MAC_UR:   r_ur   <= i_alu_res[XY_W-1:0];
                MAC_VT:   r_vt   <= i_alu_res[V_W-1:0];
                MAC_VB:   r_vb   <= i_alu_res[V_W-1:0];
                default:  r_cell <= r_cell;
            endcase
        end
    end

    // Corner order: TL, TR, BL, TR, BR, BL
    assign right  = (r_cnt == CNT_W'(1)) || (r_cnt == CNT_W'(3)) || (r_cnt == CNT_W'(4));
    assign bottom = (r_cnt == CNT_W'(2)) || (r_cnt == CNT_W'(4)) || (r_cnt == CNT_W'(5));

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            o_cell_index  <= r_cell;
            o_corner      <= r_cnt[CORNER_W-1:0];
            o_pos_x       <= right  ? r_xr : r_xl;
            o_pos_y       <= bottom ? r_yb : r_yt;
            o_tex_u       <= right  ? r_ur : r_ul;
            o_tex_v       <= bottom ? r_vb : r_vt;
            o_last_vertex <= last_emit;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// File: src/tile_to_triangle_vertex_expander.sv
`default_nettype none

// Tile-to-triangle vertex expander. Takes one signed tile number per map cell
// in row-major order and, for a non-negative tile, returns six vertices (two
// triangles: TL, TR, BL, TR, BR, BL) carrying screen position, tileset texture
// coordinate in pixels, cell index and a last flag on the sixth. A negative
// tile produces nothing but still advances the cell; the position wraps at the
// end of the map and returns to the origin on any map width or height write.
// Zero registers read as 1; oversized ones saturate. Divides and multiply-adds
// run through one shared unit: 15 restoring divide steps split the tile number
// by tiles per row, then 9 multiply-add steps form the cell index and edge
// coordinates, then the six vertices leave through an output register. A
// non-negative tile keeps ready low until its last vertex is loaded, which
// output back-pressure can delay; a negative tile leaves ready high. The user
// must write configuration only while idle; the block does not enforce it.

module tile_to_triangle_vertex_expander (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [ttve_pkg::TILE_W-1:0]     i_tile_number,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [ttve_pkg::CELL_W-1:0]            o_cell_index,
    output logic [ttve_pkg::CORNER_W-1:0]          o_corner,
    output logic [ttve_pkg::XY_W-1:0]              o_pos_x,
    output logic [ttve_pkg::XY_W-1:0]              o_pos_y,
    output logic [ttve_pkg::XY_W-1:0]              o_tex_u,
    output logic [ttve_pkg::V_W-1:0]               o_tex_v,
    output logic                                   o_last_vertex,
    input  logic                                   i_cfg_we,
    input  logic [ttve_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ttve_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import ttve_pkg::*;

    logic [SIDE_W-1:0] r_map_width, r_map_height, r_tiles_per_row;
    logic [TS_W-1:0]   r_tile_size;
    t_geom             geom;
    logic              pos_clear;
    t_alu_req          alu_req;
    logic [MAC_W-1:0]  alu_res;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        if (v == '0) begin
            clamp_side = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_MAP_SIDE)) begin
            clamp_side = SIDE_W'(MAX_MAP_SIDE);
        end else begin
            clamp_side = v;
        end
    endfunction

    function automatic logic [TS_W-1:0] clamp_ts(input logic [TS_W-1:0] v);
        if (v == '0) begin
            clamp_ts = TS_W'(1);
        end else if (v > TS_W'(MAX_TILE_SIZE)) begin
            clamp_ts = TS_W'(MAX_TILE_SIZE);
        end else begin
            clamp_ts = v;
        end
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width     <= SIDE_W'(1);
            r_map_height    <= SIDE_W'(1);
            r_tile_size     <= TS_W'(16);
            r_tiles_per_row <= SIDE_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAP_WIDTH:     r_map_width     <= i_cfg_data;
                CFG_MAP_HEIGHT:    r_map_height    <= i_cfg_data;
                CFG_TILE_SIZE:     r_tile_size     <= i_cfg_data[TS_W-1:0];
                CFG_TILES_PER_ROW: r_tiles_per_row <= i_cfg_data;
                default:           r_map_width     <= r_map_width;
            endcase
        end
    end

    // A map resize sends the position back to the origin
    assign pos_clear = i_cfg_we &&
        ((t_cfg_idx'(i_cfg_index) == CFG_MAP_WIDTH) ||
         (t_cfg_idx'(i_cfg_index) == CFG_MAP_HEIGHT));

    assign geom.w   = clamp_side(r_map_width);
    assign geom.h   = clamp_side(r_map_height);
    assign geom.ts  = clamp_ts(r_tile_size);
    assign geom.tpr = clamp_side(r_tiles_per_row);

    ttve_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    ttve_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (geom),
        .i_pos_clear   (pos_clear),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_tile_number (i_tile_number),
        .o_alu_req     (alu_req),
        .i_alu_res     (alu_res),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cell_index  (o_cell_index),
        .o_corner      (o_corner),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_tex_u       (o_tex_u),
        .o_tex_v       (o_tex_v),
        .o_last_vertex (o_last_vertex)
    );

endmodule

`default_nettype wire

// File: src/ttve_checker.sv
`default_nettype none

`include "tile_to_triangle_vertex_expander_macros.svh"

module ttve_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_ready,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic [ttve_pkg::CELL_W-1:0]         o_cell_index,
    input  logic [ttve_pkg::CORNER_W-1:0]       o_corner,
    input  logic [ttve_pkg::XY_W-1:0]           o_pos_x,
    input  logic [ttve_pkg::XY_W-1:0]           o_pos_y,
    input  logic [ttve_pkg::XY_W-1:0]           o_tex_u,
    input  logic [ttve_pkg::V_W-1:0]            o_tex_v,
    input  logic                                o_last_vertex
);
    import ttve_pkg::*;

    logic out_stall;
    assign out_stall = o_valid && !i_ready;

    // A stalled vertex request holds its payload
    `TTVE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_valid && $stable(o_cell_index) && $stable(o_corner) && $stable(o_pos_x) && $stable(o_pos_y) && $stable(o_tex_u) && $stable(o_tex_v), "vertex payload changed while stalled")

    // Corner slot stays within one cell's six vertices
    `TTVE_ASSERT_IMP(a_corner_range, i_clk, i_rst_n, o_valid, o_corner <= CORNER_W'(VERTS - 1), "corner out of range")

    // Last flag marks exactly the final corner
    `TTVE_ASSERT_IMP(a_last_flag, i_clk, i_rst_n, o_valid, o_last_vertex == (o_corner == CORNER_W'(VERTS - 1)), "last flag and corner disagree")

    // No new tile is taken while a cell is still being emitted
    `TTVE_ASSERT_IMP(a_busy_mid_cell, i_clk, i_rst_n, o_valid && !o_last_vertex, !o_ready, "ready while cell vertices pending")

endmodule

bind tile_to_triangle_vertex_expander ttve_checker u_ttve_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_cell_index  (o_cell_index),
    .o_corner      (o_corner),
    .o_pos_x       (o_pos_x),
    .o_pos_y       (o_pos_y),
    .o_tex_u       (o_tex_u),
    .o_tex_v       (o_tex_v),
    .o_last_vertex (o_last_vertex)
);

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ttve_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    // Corners that take the right or bottom tile edge, one bit per corner slot
    localparam logic [VERTS-1:0] RIGHT_CORNERS  = 6'b011010;
    localparam logic [VERTS-1:0] BOTTOM_CORNERS = 6'b110100;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_idx;
        logic [CORNER_W-1:0] corner;
        logic [XY_W-1:0]     x;
        logic [XY_W-1:0]     y;
        logic [XY_W-1:0]     u;
        logic [V_W-1:0]      v;
        logic                last;
    } t_vertex;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic signed [TILE_W-1:0]   i_tile_number = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [CELL_W-1:0]          o_cell_index;
    logic [CORNER_W-1:0]        o_corner;
    logic [XY_W-1:0]            o_pos_x;
    logic [XY_W-1:0]            o_pos_y;
    logic [XY_W-1:0]            o_tex_u;
    logic [V_W-1:0]             o_tex_v;
    logic                       o_last_vertex;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    // Pending tile requests and the vertices they should produce
    logic signed [TILE_W-1:0]   pending_tiles[$];
    t_vertex                    expected_vertices[$];

    // Model copy of the registers and the cell position
    logic [SIDE_W-1:0]          geo_w = 11'd1;
    logic [SIDE_W-1:0]          geo_h = 11'd1;
    logic [TS_W-1:0]            geo_ts = 9'd16;
    logic [SIDE_W-1:0]          geo_tpr = 11'd1;
    int unsigned                cur_col = 0;
    int unsigned                cur_row = 0;

    int                         send_idle_pct = 0;
    int                         stall_pct = 0;
    int                         tiles_taken = 0;
    int                         vertices_checked = 0;
    int                         reg_writes = 0;
    int                         mismatches = 0;

    tile_to_triangle_vertex_expander u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_tile_number  (i_tile_number),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cell_index   (o_cell_index),
        .o_corner       (o_corner),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_tex_u        (o_tex_u),
        .o_tex_v        (o_tex_v),
        .o_last_vertex  (o_last_vertex),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Zero reads as one, anything above the limit saturates
    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void step_cell(int unsigned w, int unsigned h);
        cur_col++;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h) cur_row = 0;
        end
    endfunction

    // Work out the six vertices of one tile request and advance the position
    function automatic void expand_tile(logic signed [TILE_W-1:0] tile);
        int unsigned     w, h, ts, tpr, raw, tu, tv;
        longint unsigned cell_idx, xl, xr, yt, yb, ul, ur, vt, vb;
        t_vertex         vx;
        w   = clamp_reg(32'(geo_w), MAX_MAP_SIDE);
        h   = clamp_reg(32'(geo_h), MAX_MAP_SIDE);
        ts  = clamp_reg(32'(geo_ts), MAX_TILE_SIZE);
        tpr = clamp_reg(32'(geo_tpr), MAX_MAP_SIDE);
        raw = 32'(tile[TILE_W-2:0]);
        if (cur_col >= w || cur_row >= h) begin
            cur_col = 0;
            cur_row = 0;
        end
        // Empty cell: nothing out, position still moves on
        if (tile < 0) begin
            step_cell(w, h);
            return;
        end
        tu       = raw % tpr;
        tv       = raw / tpr;
        cell_idx = longint'(cur_row) * w + cur_col;
        xl       = longint'(cur_col) * ts;
        xr       = (longint'(cur_col) + 1) * ts;
        yt       = longint'(cur_row) * ts;
        yb       = (longint'(cur_row) + 1) * ts;
        ul       = longint'(tu) * ts;
        ur       = (longint'(tu) + 1) * ts;
        vt       = longint'(tv) * ts;
        vb       = (longint'(tv) + 1) * ts;
        for (int k = 0; k < VERTS; k++) begin
            vx.cell_idx = cell_idx[CELL_W-1:0];
            vx.corner   = k[CORNER_W-1:0];
            vx.x        = RIGHT_CORNERS[k] ? xr[XY_W-1:0] : xl[XY_W-1:0];
            vx.y        = BOTTOM_CORNERS[k] ? yb[XY_W-1:0] : yt[XY_W-1:0];
            vx.u        = RIGHT_CORNERS[k] ? ur[XY_W-1:0] : ul[XY_W-1:0];
            vx.v        = BOTTOM_CORNERS[k] ? vb[V_W-1:0] : vt[V_W-1:0];
            vx.last     = (k == VERTS - 1);
            expected_vertices.push_back(vx);
        end
        step_cell(w, h);
    endfunction

    // Request driver: presents queued tiles, idling at random between them
    always @(posedge i_clk) begin : tile_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expand_tile(i_tile_number);
                tiles_taken++;
            end
            if (!i_valid || o_ready) begin
                if (pending_tiles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid       <= 1'b1;
                    i_tile_number <= pending_tiles.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Vertex monitor: stalls at random, checks each vertex taken
    always @(posedge i_clk) begin : vertex_monitor
        t_vertex got, want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{o_cell_index, o_corner, o_pos_x, o_pos_y, o_tex_u, o_tex_v,
                        o_last_vertex};
                if (expected_vertices.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected vertex: cell %0d corner %0d", got.cell_idx,
                                 got.corner);
                end else begin
                    want = expected_vertices.pop_front();
                    vertices_checked++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("vertex mismatch, expected: cell %0d corner %0d",
                                     want.cell_idx, want.corner,
                                     " x %0d y %0d u %0d v %0d last %0b",
                                     want.x, want.y, want.u, want.v, want.last);
                            $display("                 actual:   cell %0d corner %0d",
                                     got.cell_idx, got.corner,
                                     " x %0d y %0d u %0d v %0d last %0b",
                                     got.x, got.y, got.u, got.v, got.last);
                        end
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // One register write while the block is idle; the model follows at once
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_MAP_WIDTH: begin
                geo_w   = data;
                cur_col = 0;
                cur_row = 0;
            end
            CFG_MAP_HEIGHT: begin
                geo_h   = data;
                cur_col = 0;
                cur_row = 0;
            end
            CFG_TILE_SIZE:     geo_ts  = data[TS_W-1:0];
            CFG_TILES_PER_ROW: geo_tpr = data;
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                                logic [CFG_DATA_W-1:0] ts, logic [CFG_DATA_W-1:0] tpr);
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_TILE_SIZE, ts);
        write_reg(CFG_TILES_PER_ROW, tpr);
    endtask

    // Mostly small maps so the position wraps often, now and then a wild value
    function automatic logic [CFG_DATA_W-1:0] random_side();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return CFG_DATA_W'($urandom_range(2047));
        return CFG_DATA_W'($urandom_range(1, 16));
    endfunction

    // Wait until every request is taken and every vertex back, then let
    // an empty-cell request still in flight finish
    task automatic drain();
        @(negedge i_clk);
        while (pending_tiles.size() > 0 || i_valid || expected_vertices.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random_tiles(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1)) pending_tiles.push_back(TILE_W'($urandom));
            else pending_tiles.push_back(TILE_W'($urandom_range(0, 2000)));
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: one-cell map, so every request wraps to the origin
        pending_tiles.push_back(16'sd0);
        pending_tiles.push_back(16'sd1);
        pending_tiles.push_back(16'sd32767);
        pending_tiles.push_back(-16'sd1);
        pending_tiles.push_back(-16'sd32768);
        drain();

        // Largest tile and tileset row, map wraps after six cells
        set_geometry(11'd3, 11'd2, 11'd256, 11'd1024);
        pending_tiles.push_back(16'sd0);
        pending_tiles.push_back(16'sd1023);
        pending_tiles.push_back(16'sd1024);
        pending_tiles.push_back(16'sd32767);
        pending_tiles.push_back(-16'sd5);
        pending_tiles.push_back(16'sd2047);
        pending_tiles.push_back(16'sd7);
        drain();

        // Zero registers read as one
        set_geometry(11'd0, 11'd0, 11'd0, 11'd0);
        pending_tiles.push_back(16'sd3);
        pending_tiles.push_back(-16'sd2);
        pending_tiles.push_back(16'sd9);
        drain();

        // Oversized registers saturate; tile size keeps only its low bits
        set_geometry(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
        pending_tiles.push_back(16'sd32767);
        pending_tiles.push_back(16'sd1);
        pending_tiles.push_back(16'sh7C00);
        drain();

        // Map resize part way through the map sends the position home
        set_geometry(11'd5, 11'd4, 11'd1, 11'd7);
        pending_tiles.push_back(16'sd10);
        pending_tiles.push_back(16'sd20);
        pending_tiles.push_back(-16'sd1);
        pending_tiles.push_back(16'sd30);
        drain();
        write_reg(CFG_MAP_HEIGHT, 11'd4);
        pending_tiles.push_back(16'sd40);
        pending_tiles.push_back(16'sd50);
        drain();

        // Random phases: none, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 67 : (ph == 3) ? 28 : 0;
            stall_pct     = (ph == 2) ? 67 : (ph == 3) ? 28 : 0;
            set_geometry(random_side(), random_side(), CFG_DATA_W'($urandom_range(2047)),
                         ($urandom_range(2) == 0) ? CFG_DATA_W'($urandom_range(2047))
                                                  : CFG_DATA_W'($urandom_range(1, 64)));
            queue_random_tiles(50);
            // sender holds off until the block has returned everything
            drain();
            if ($urandom_range(1)) write_reg(CFG_MAP_WIDTH, random_side());
            queue_random_tiles(50);
            drain();
        end

        $display("covered %0d tile requests, %0d vertices checked, %0d register writes",
                 tiles_taken, vertices_checked, reg_writes);
        $display("reset, empty, zero, saturated and resized geometries under four idle mixes");
        if (mismatches == 0 && expected_vertices.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d vertices outstanding", mismatches,
                     expected_vertices.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d vertices outstanding", expected_vertices.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
